/* src/drf_pkg.sv */
`default_nettype none

package drf_pkg;

    // Action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_MOVE  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Buffer select codes
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // Width of the count fields in a result
    localparam int CNT_W = 3;

    typedef struct packed {
        logic [1:0] action;
        logic       buffer_sel;
        logic       source_sel;
        logic [7:0] write_value;
    } in_t;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             ok;
        logic [CNT_W-1:0] moved_count;
        logic [CNT_W-1:0] level;
        logic [CNT_W-1:0] free_slots;
        logic             is_empty;
        logic             is_full;
    } out_t;

    // Pointer update request for one ring
    typedef struct packed {
        logic clear;
        logic inc_head;
        logic inc_tail;
    } ring_cmd_t;

endpackage

`default_nettype wire

/* src/drf_ram.sv */
`default_nettype none

module drf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/drf_ring.sv */
`default_nettype none

// Head/tail pointers of one ring and its fill level.
module drf_ring #(
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire drf_pkg::ring_cmd_t       cmd,
    output logic      [$clog2(DEPTH)-1:0] head,
    output logic      [$clog2(DEPTH)-1:0] tail,
    output logic      [$clog2(DEPTH)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW:0]   diff;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.clear) begin
            head_next = '0;
            tail_next = '0;
        end else begin
            if (cmd.inc_head) begin
                head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            end
            if (cmd.inc_tail) begin
                tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            end
        end
    end

    // tail - head modulo DEPTH, valid for any DEPTH
    always_comb begin
        if (tail_reg >= head_reg) begin
            diff = {1'b0, tail_reg} - {1'b0, head_reg};
        end else begin
            diff = {1'b0, tail_reg} + DEPTH_W - {1'b0, head_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    assign head  = head_reg;
    assign tail  = tail_reg;
    assign level = diff[PW-1:0];

endmodule

`default_nettype wire

/* src/dual_ring_fifo_with_move.sv */
`default_nettype none
// Path, input transaction to result valid: write, clear, an empty read
// or a move that copies nothing go EXEC then RESULT; a read that pops
// adds RDWAIT for the registered memory read; a move of n > 0 bytes adds
// MOVE, copying one byte per cycle. A new transaction is taken only after
// the last result is built; a result held back by m_ready adds its wait.
// Reset: aresetn synchronous, active low; clears all pointers and control.

module dual_ring_fifo_with_move #(
    parameter int DEPTH = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire drf_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output drf_pkg::out_t       m_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = (PW > drf_pkg::CNT_W) ? PW : drf_pkg::CNT_W;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    // Sequencer:
    //   IDLE   - takes one input transaction
    //   EXEC   - write / clear / pointer checks; read issues the RAM read
    //   RDWAIT - read data returns from the registered RAM port
    //   MOVE   - one source read issued and one destination write per cycle,
    //            the write following its read in the next cycle
    //   RESULT - builds the result, waits for the output register to free
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_MOVE,
        ST_RESULT
    } state_t;

    state_t          state_reg, state_next;
    drf_pkg::in_t    cmd_reg, cmd_next;
    logic [PW-1:0]   issue_left_reg, issue_left_next;
    logic            pend_reg, pend_next;
    logic [PW-1:0]   moved_reg, moved_next;
    logic            ok_reg, ok_next;
    logic [7:0]      rdata_reg, rdata_next;
    logic            m_valid_reg, m_valid_next;
    drf_pkg::out_t   out_reg, out_next;

    // Per-ring signals, index 0 is A and 1 is B
    drf_pkg::ring_cmd_t ring_cmd [2];
    logic [PW-1:0]      head     [2];
    logic [PW-1:0]      tail     [2];
    logic [PW-1:0]      lvl      [2];
    logic [7:0]         ram_rd   [2];
    logic [1:0]         ram_we;
    logic [7:0]         ram_wd;

    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_ring
            drf_ring #(
                .DEPTH (DEPTH)
            ) u_ring (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (ring_cmd[g]),
                .head    (head[g]),
                .tail    (tail[g]),
                .level   (lvl[g])
            );

            // Read port always sits at the head: the byte to pop or move.
            drf_ram #(
                .WIDTH (8),
                .DEPTH (DEPTH)
            ) u_ram (
                .clk     (aclk),
                .wr_en   (ram_we[g]),
                .wr_addr (tail[g]),
                .wr_data (ram_wd),
                .rd_addr (head[g]),
                .rd_data (ram_rd[g])
            );
        end
    endgenerate

    logic          dsel, ssel;
    logic [PW-1:0] dst_lvl, src_lvl, dst_free, move_n;
    logic          dst_empty, dst_full;
    logic [LW-1:0] lvl_w, free_w, moved_w;

    assign dsel      = cmd_reg.buffer_sel;
    assign ssel      = cmd_reg.source_sel;
    assign dst_lvl   = lvl[dsel];
    assign src_lvl   = lvl[ssel];
    assign dst_free  = LAST - dst_lvl;
    assign dst_empty = (dst_lvl == '0);
    assign dst_full  = (dst_lvl == LAST);
    assign move_n    = (src_lvl < dst_free) ? src_lvl : dst_free;

    // Counts are reported modulo 8
    assign lvl_w   = LW'(dst_lvl);
    assign free_w  = LW'(dst_free);
    assign moved_w = LW'(moved_reg);

    // Write data: the input byte for a write, the source read data for a move
    assign ram_wd = (state_reg == ST_EXEC) ? cmd_reg.write_value : ram_rd[ssel];

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        issue_left_next = issue_left_reg;
        pend_next       = 1'b0;
        moved_next      = moved_reg;
        ok_next         = ok_reg;
        rdata_next      = rdata_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        ram_we          = '0;
        for (int i = 0; i < 2; i++) begin
            ring_cmd[i] = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    moved_next = '0;
                    ok_next    = 1'b0;
                    rdata_next = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESULT;
                case (cmd_reg.action)
                    drf_pkg::ACT_WRITE: begin
                        if (!dst_full) begin
                            ram_we[dsel]            = 1'b1;
                            ring_cmd[dsel].inc_tail = 1'b1;
                            ok_next                 = 1'b1;
                        end
                    end
                    drf_pkg::ACT_READ: begin
                        if (!dst_empty) begin
                            ring_cmd[dsel].inc_head = 1'b1;
                            ok_next                 = 1'b1;
                            state_next              = ST_RDWAIT;
                        end
                    end
                    drf_pkg::ACT_MOVE: begin
                        if (ssel != dsel && move_n != '0) begin
                            issue_left_next = move_n;
                            moved_next      = move_n;
                            ok_next         = 1'b1;
                            state_next      = ST_MOVE;
                        end
                    end
                    drf_pkg::ACT_CLEAR: begin
                        ring_cmd[dsel].clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RDWAIT: begin
                rdata_next = ram_rd[dsel];
                state_next = ST_RESULT;
            end
            ST_MOVE: begin
                if (issue_left_reg != '0) begin
                    ring_cmd[ssel].inc_head = 1'b1;
                    issue_left_next         = issue_left_reg - 1'b1;
                    pend_next               = 1'b1;
                end
                if (pend_reg) begin
                    ram_we[dsel]            = 1'b1;
                    ring_cmd[dsel].inc_tail = 1'b1;
                end
                // last write goes out in the cycle after the last read
                if (issue_left_reg == '0) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.read_data   = rdata_reg;
                    out_next.ok          = ok_reg;
                    out_next.moved_count = moved_w[drf_pkg::CNT_W-1:0];
                    out_next.level       = lvl_w[drf_pkg::CNT_W-1:0];
                    out_next.free_slots  = free_w[drf_pkg::CNT_W-1:0];
                    out_next.is_empty    = dst_empty;
                    out_next.is_full     = dst_full;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_left_reg <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_left_reg <= issue_left_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg   <= cmd_next;
        moved_reg <= moved_next;
        ok_reg    <= ok_next;
        rdata_reg <= rdata_next;
        out_reg   <= out_next;
    end

    // A new transaction is taken only in IDLE; a finished result may still
    // be waiting in the output register meanwhile.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    // A move never writes into a full destination
    a_move_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE && pend_reg) |-> !dst_full)
        else $error("move write into full buffer");

    // Moves only run between two different rings
    a_move_rings: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |-> (cmd_reg.source_sel != cmd_reg.buffer_sel))
        else $error("move with source equal to destination");

    // An accepted transaction always starts execution next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not executed");
`endif

endmodule

`default_nettype wire
